FILE: rtl/bpc_pkg.sv
package bpc_pkg;

  localparam int unsigned MAX_BUTTONS_DEF = 8;
  // the button field is three bits wide, so no more than eight entries can be addressed
  localparam int unsigned BUTTON_FIELD_SPAN = 8;

  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_POLL = 1'b1;

  localparam logic [2:0] CFG_NUM_BUTTONS     = 3'd0;
  localparam logic [2:0] CFG_LONG_DELAY      = 3'd1;
  localparam logic [2:0] CFG_VERY_LONG_DELAY = 3'd2;
  localparam logic [2:0] CFG_DEFAULT_DEBOUNCE = 3'd3;
  localparam logic [2:0] CFG_INITIAL_LEVELS  = 3'd4;

  localparam logic [3:0]  NUM_BUTTONS_RST      = 4'd0;
  localparam logic [15:0] LONG_DELAY_RST       = 16'd1000;
  localparam logic [15:0] VERY_LONG_DELAY_RST  = 16'd2000;
  localparam logic [15:0] DEFAULT_DEBOUNCE_RST = 16'd50;
  localparam logic [7:0]  INITIAL_LEVELS_RST   = 8'd0;

  typedef enum logic [2:0] {
    ST_DOWN   = 3'd0,
    ST_SHORT  = 3'd1,
    ST_LONG   = 3'd2,
    ST_VLONG  = 3'd3,
    ST_DOUBLE = 3'd4,
    ST_UP     = 3'd5,
    ST_STOP   = 3'd6
  } press_state_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_SHORT   = 3'd1,
    EV_LONG    = 3'd2,
    EV_VLONG   = 3'd3,
    EV_DOUBLE  = 3'd4,
    EV_RELEASE = 3'd5
  } press_event_e;

  typedef struct packed {
    logic        func;
    logic [2:0]  button;
    logic [31:0] now;
    logic        pin_level;
    logic [15:0] debounce_count;
  } in_item_t;

  typedef struct packed {
    press_event_e press_event;
    logic         accepted;
    press_state_e fsm_state;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  num_buttons;
    logic [15:0] long_delay;
    logic [15:0] very_long_delay;
    logic [15:0] default_debounce;
    logic [7:0]  initial_levels;
  } cfg_t;

  typedef struct packed {
    press_state_e press_state;
    press_state_e previous_state;
    logic         latched_level;
    logic [31:0]  press_start;
    logic [31:0]  last_release;
    logic [31:0]  debounce_deadline;
  } entry_t;

endpackage

FILE: rtl/bpc_cfg_regs.sv
module bpc_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  output bpc_pkg::cfg_t cfg_o,
  output logic          levels_load_o
);

  bpc_pkg::cfg_t cfg_q, cfg_d;
  logic          wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i;

  always_comb begin
    cfg_d = cfg_q;
    levels_load_o = 1'b0;
    if (wr) begin
      unique case (cfg_index_i)
        bpc_pkg::CFG_NUM_BUTTONS:      cfg_d.num_buttons = cfg_data_i[3:0];
        bpc_pkg::CFG_LONG_DELAY:       cfg_d.long_delay = cfg_data_i;
        bpc_pkg::CFG_VERY_LONG_DELAY:  cfg_d.very_long_delay = cfg_data_i;
        bpc_pkg::CFG_DEFAULT_DEBOUNCE: cfg_d.default_debounce = cfg_data_i;
        bpc_pkg::CFG_INITIAL_LEVELS: begin
          cfg_d.initial_levels = cfg_data_i[7:0];
          levels_load_o = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_buttons      <= bpc_pkg::NUM_BUTTONS_RST;
      cfg_q.long_delay       <= bpc_pkg::LONG_DELAY_RST;
      cfg_q.very_long_delay  <= bpc_pkg::VERY_LONG_DELAY_RST;
      cfg_q.default_debounce <= bpc_pkg::DEFAULT_DEBOUNCE_RST;
      cfg_q.initial_levels   <= bpc_pkg::INITIAL_LEVELS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/bpc_step.sv
module bpc_step #(
  parameter int unsigned MAX_BUTTONS_P = bpc_pkg::MAX_BUTTONS_DEF
) (
  input  bpc_pkg::in_item_t  item_i,
  input  bpc_pkg::cfg_t      cfg_i,
  input  bpc_pkg::entry_t    cur_i,
  output bpc_pkg::entry_t    nxt_o,
  output logic               write_o,
  output bpc_pkg::out_item_t res_o
);

  logic                  accept;
  logic [31:0]           deb_ticks;
  logic [31:0]           held;
  logic [31:0]           since_release;
  logic                  expired;
  bpc_pkg::press_state_e next_st;
  bpc_pkg::press_event_e ev;

  assign accept = ({1'b0, item_i.button} < cfg_i.num_buttons)
                  && (32'(item_i.button) < MAX_BUTTONS_P);
  assign deb_ticks = (item_i.debounce_count != 16'd0) ? 32'(item_i.debounce_count)
                                                       : 32'(cfg_i.default_debounce);
  assign held          = item_i.now - cur_i.press_start;
  assign since_release = item_i.now - cur_i.last_release;
  assign expired = (cur_i.debounce_deadline != 32'd0)
                   && (item_i.now > cur_i.debounce_deadline);

  // one step of the press machine
  always_comb begin
    next_st = bpc_pkg::ST_STOP;
    ev      = bpc_pkg::EV_NONE;
    unique case (cur_i.press_state)
      bpc_pkg::ST_DOWN: next_st = bpc_pkg::ST_SHORT;
      bpc_pkg::ST_SHORT: begin
        if (!cur_i.latched_level) begin
          next_st = bpc_pkg::ST_UP;
        end else if (held > 32'(cfg_i.long_delay)) begin
          next_st = bpc_pkg::ST_LONG;
        end else if (since_release < 32'(cfg_i.long_delay)) begin
          next_st = bpc_pkg::ST_DOUBLE;
        end else begin
          next_st = bpc_pkg::ST_SHORT;
          if (cur_i.previous_state != bpc_pkg::ST_SHORT) ev = bpc_pkg::EV_SHORT;
        end
      end
      bpc_pkg::ST_LONG: begin
        if (!cur_i.latched_level) begin
          next_st = bpc_pkg::ST_UP;
        end else if (held > 32'(cfg_i.very_long_delay)) begin
          next_st = bpc_pkg::ST_VLONG;
        end else begin
          next_st = bpc_pkg::ST_LONG;
          if (cur_i.previous_state != bpc_pkg::ST_LONG) ev = bpc_pkg::EV_LONG;
        end
      end
      bpc_pkg::ST_VLONG: begin
        if (!cur_i.latched_level) begin
          next_st = bpc_pkg::ST_UP;
        end else begin
          next_st = bpc_pkg::ST_VLONG;
          if (cur_i.previous_state != bpc_pkg::ST_VLONG) ev = bpc_pkg::EV_VLONG;
        end
      end
      bpc_pkg::ST_DOUBLE: begin
        next_st = bpc_pkg::ST_UP;
        ev      = bpc_pkg::EV_DOUBLE;
      end
      bpc_pkg::ST_UP: begin
        next_st = bpc_pkg::ST_STOP;
        ev      = bpc_pkg::EV_RELEASE;
      end
      default: next_st = bpc_pkg::ST_STOP;
    endcase
  end

  always_comb begin
    nxt_o             = cur_i;
    write_o           = accept;
    res_o.press_event = bpc_pkg::EV_NONE;
    res_o.accepted    = 1'b1;
    if (!accept) begin
      res_o.accepted = 1'b0;
    end else if (item_i.func == bpc_pkg::FUNC_EDGE) begin
      // a sum of zero after wrap means no debounce pending
      nxt_o.debounce_deadline = item_i.now + deb_ticks;
    end else if (expired) begin
      nxt_o.debounce_deadline = 32'd0;
      if (item_i.pin_level != cur_i.latched_level) begin
        nxt_o.latched_level = item_i.pin_level;
        if (item_i.pin_level && cur_i.press_state == bpc_pkg::ST_STOP) begin
          nxt_o.press_state = bpc_pkg::ST_DOWN;
        end
      end
    end else if (cur_i.press_state != bpc_pkg::ST_STOP) begin
      nxt_o.previous_state = cur_i.press_state;
      nxt_o.press_state    = next_st;
      res_o.press_event    = ev;
      if (cur_i.press_state == bpc_pkg::ST_DOWN) nxt_o.press_start = item_i.now;
      if (cur_i.press_state == bpc_pkg::ST_UP) nxt_o.last_release = item_i.now;
    end
    res_o.fsm_state = accept ? nxt_o.press_state : bpc_pkg::ST_STOP;
  end

endmodule

FILE: rtl/button_press_classifier_unit.sv
// press classifier for up to MAX_BUTTONS_P push buttons, addressed by index
// input channel: in_valid_i / in_stall_o carry one item (edge notification or poll
//   pass for one button); the beat is taken when valid is high and stall is low
// output channel: out_valid_o / out_stall_i carry exactly one result per input beat
// config channel: cfg_valid_i / cfg_ready_o write register cfg_index_i with
//   cfg_data_i; ready is always high, writes are meant only while the block is idle
// path: the input register takes the beat, then the state table update and the result
//   register load together on the same edge
// throughput: one item per cycle while no result is held; per-button state sits in
//   flip-flops and the read-modify-write of one entry fits between the input and
//   result registers, so items on the same button may follow back to back
// reset: every button stopped, no debounce pending, times zero, registers at
//   their defaults; the block takes items in the first cycle after reset
// stall: a held result freezes the output register; the input register then
//   fills and in_stall_o rises until the result is taken
module button_press_classifier_unit #(
  parameter int unsigned MAX_BUTTONS_P = bpc_pkg::MAX_BUTTONS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bpc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bpc_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int unsigned StoreDepth = (MAX_BUTTONS_P < bpc_pkg::BUTTON_FIELD_SPAN)
                                       ? MAX_BUTTONS_P : bpc_pkg::BUTTON_FIELD_SPAN;
  localparam int unsigned IdxW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  bpc_pkg::cfg_t      cfg;
  logic               levels_load;
  bpc_pkg::in_item_t  item_q;
  logic               item_valid_q;
  bpc_pkg::out_item_t res_d, res_q;
  logic               res_valid_q;
  logic               advance;
  logic [IdxW-1:0]    idx;
  bpc_pkg::entry_t    entry_q [StoreDepth];
  bpc_pkg::entry_t    cur, nxt;
  logic               wr;

  bpc_cfg_regs u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cfg_o         (cfg),
    .levels_load_o (levels_load)
  );

  // an item is held and the result register is free or draining this cycle
  assign advance    = item_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) item_q <= in_data_i;
  end

  // out-of-range indexes alias an entry here but never write it
  assign idx = IdxW'(item_q.button);
  assign cur = entry_q[idx];

  bpc_step #(
    .MAX_BUTTONS_P (MAX_BUTTONS_P)
  ) u_step (
    .item_i  (item_q),
    .cfg_i   (cfg),
    .cur_i   (cur),
    .nxt_o   (nxt),
    .write_o (wr),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StoreDepth; i++) begin
        entry_q[i].press_state       <= bpc_pkg::ST_STOP;
        entry_q[i].previous_state    <= bpc_pkg::ST_DOWN;
        entry_q[i].latched_level     <= bpc_pkg::INITIAL_LEVELS_RST[i];
        entry_q[i].press_start       <= 32'd0;
        entry_q[i].last_release      <= 32'd0;
        entry_q[i].debounce_deadline <= 32'd0;
      end
    end else if (levels_load) begin
      for (int i = 0; i < StoreDepth; i++) begin
        entry_q[i].latched_level <= cfg_data_i[i];
      end
    end else if (advance && wr) begin
      entry_q[idx] <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

FILE: tb/button_press_classifier_unit_tb.sv
module button_press_classifier_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  class press_tracker;
    logic [3:0]            num_buttons;
    logic [15:0]           long_delay;
    logic [15:0]           very_long_delay;
    logic [15:0]           default_debounce;
    logic [7:0]            initial_levels;
    bpc_pkg::press_state_e state_q [bpc_pkg::MAX_BUTTONS_DEF];
    bpc_pkg::press_state_e prev_q [bpc_pkg::MAX_BUTTONS_DEF];
    logic                  level_q [bpc_pkg::MAX_BUTTONS_DEF];
    logic [31:0]           start_q [bpc_pkg::MAX_BUTTONS_DEF];
    logic [31:0]           released_q [bpc_pkg::MAX_BUTTONS_DEF];
    logic [31:0]           deadline_q [bpc_pkg::MAX_BUTTONS_DEF];
    bpc_pkg::out_item_t    awaited [$];
    int unsigned           errors;
    int unsigned           matched;
    int unsigned           rejected;
    int unsigned           event_hits [8];

    function new();
      num_buttons      = bpc_pkg::NUM_BUTTONS_RST;
      long_delay       = bpc_pkg::LONG_DELAY_RST;
      very_long_delay  = bpc_pkg::VERY_LONG_DELAY_RST;
      default_debounce = bpc_pkg::DEFAULT_DEBOUNCE_RST;
      initial_levels   = bpc_pkg::INITIAL_LEVELS_RST;
      for (int i = 0; i < bpc_pkg::MAX_BUTTONS_DEF; i++) begin
        state_q[i]    = bpc_pkg::ST_STOP;
        prev_q[i]     = bpc_pkg::ST_DOWN;
        level_q[i]    = initial_levels[i];
        start_q[i]    = '0;
        released_q[i] = '0;
        deadline_q[i] = '0;
      end
      errors = 0;
      matched = 0;
      rejected = 0;
      foreach (event_hits[i]) event_hits[i] = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        bpc_pkg::CFG_NUM_BUTTONS:      num_buttons = val[3:0];
        bpc_pkg::CFG_LONG_DELAY:       long_delay = val;
        bpc_pkg::CFG_VERY_LONG_DELAY:  very_long_delay = val;
        bpc_pkg::CFG_DEFAULT_DEBOUNCE: default_debounce = val;
        bpc_pkg::CFG_INITIAL_LEVELS: begin
          initial_levels = val[7:0];
          // reloads the debounced level of every button
          for (int i = 0; i < bpc_pkg::MAX_BUTTONS_DEF; i++) level_q[i] = initial_levels[i];
        end
        default: ;
      endcase
    endfunction

    function void classify_item(bpc_pkg::in_item_t it);
      bpc_pkg::out_item_t    exp;
      int unsigned           b;
      bpc_pkg::press_state_e cur;
      bpc_pkg::press_state_e nxt;
      logic [31:0]           held;
      logic [31:0]           since;
      b = it.button;
      exp.press_event = bpc_pkg::EV_NONE;
      exp.accepted = 1'b1;
      if (b >= num_buttons || b >= bpc_pkg::MAX_BUTTONS_DEF) begin
        exp.accepted = 1'b0;
        exp.fsm_state = bpc_pkg::ST_STOP;
        rejected++;
        awaited.push_back(exp);
        return;
      end
      if (it.func == bpc_pkg::FUNC_EDGE) begin
        deadline_q[b] = it.now + ((it.debounce_count != 0) ? 32'(it.debounce_count)
                                                            : 32'(default_debounce));
      end else if (deadline_q[b] != 0 && it.now > deadline_q[b]) begin
        deadline_q[b] = '0;
        if (it.pin_level != level_q[b]) begin
          level_q[b] = it.pin_level;
          if (it.pin_level && state_q[b] == bpc_pkg::ST_STOP) state_q[b] = bpc_pkg::ST_DOWN;
        end
      end else if (state_q[b] != bpc_pkg::ST_STOP) begin
        cur = state_q[b];
        held = it.now - start_q[b];
        since = it.now - released_q[b];
        nxt = bpc_pkg::ST_STOP;
        case (cur)
          bpc_pkg::ST_DOWN: begin
            start_q[b] = it.now;
            nxt = bpc_pkg::ST_SHORT;
          end
          bpc_pkg::ST_SHORT: begin
            if (!level_q[b]) nxt = bpc_pkg::ST_UP;
            else if (held > 32'(long_delay)) nxt = bpc_pkg::ST_LONG;
            else if (since < 32'(long_delay)) nxt = bpc_pkg::ST_DOUBLE;
            else begin
              if (prev_q[b] != bpc_pkg::ST_SHORT) exp.press_event = bpc_pkg::EV_SHORT;
              nxt = bpc_pkg::ST_SHORT;
            end
          end
          bpc_pkg::ST_LONG: begin
            if (!level_q[b]) nxt = bpc_pkg::ST_UP;
            else if (held > 32'(very_long_delay)) nxt = bpc_pkg::ST_VLONG;
            else begin
              if (prev_q[b] != bpc_pkg::ST_LONG) exp.press_event = bpc_pkg::EV_LONG;
              nxt = bpc_pkg::ST_LONG;
            end
          end
          bpc_pkg::ST_VLONG: begin
            if (!level_q[b]) nxt = bpc_pkg::ST_UP;
            else begin
              if (prev_q[b] != bpc_pkg::ST_VLONG) exp.press_event = bpc_pkg::EV_VLONG;
              nxt = bpc_pkg::ST_VLONG;
            end
          end
          bpc_pkg::ST_DOUBLE: begin
            exp.press_event = bpc_pkg::EV_DOUBLE;
            nxt = bpc_pkg::ST_UP;
          end
          bpc_pkg::ST_UP: begin
            released_q[b] = it.now;
            exp.press_event = bpc_pkg::EV_RELEASE;
            nxt = bpc_pkg::ST_STOP;
          end
          default: nxt = bpc_pkg::ST_STOP;
        endcase
        prev_q[b] = cur;
        state_q[b] = nxt;
      end
      exp.fsm_state = state_q[b];
      event_hits[exp.press_event]++;
      awaited.push_back(exp);
    endfunction

    function void compare_field(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(bpc_pkg::out_item_t got);
      bpc_pkg::out_item_t exp;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got event %0d accepted %0d state %0d",
                 $time, got.press_event, got.accepted, got.fsm_state);
        return;
      end
      exp = awaited.pop_front();
      compare_field("press_event", exp.press_event, got.press_event);
      compare_field("accepted", 3'(exp.accepted), 3'(got.accepted));
      compare_field("fsm_state", exp.fsm_state, got.fsm_state);
      matched++;
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  bpc_pkg::in_item_t  in_beat = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bpc_pkg::out_item_t out_beat;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  press_tracker tracker;
  int unsigned  cycles = 0;
  int unsigned  items_sent = 0;
  logic [31:0]  tick_now = '0;
  bit           in_quiet = 1'b0;
  bit           out_quiet = 1'b0;
  int unsigned  stall_left = 0;
  int unsigned  stall_roll;

  button_press_classifier_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.classify_item(in_beat);
      if (out_valid && !out_stall) tracker.check_result(out_beat);
    end
  end

  // receiver back-pressure: mostly short stalls, now and then a long one
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) out_quiet = !out_quiet;
    stall_roll = $urandom_range(0, 99);
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (out_quiet || stall_roll < 65) begin
      out_stall <= 1'b0;
    end else if (stall_roll < 95) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      stall_left = $urandom_range(8, 40);
      out_stall <= 1'b1;
    end
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("FAIL button_press_classifier_unit");
    $finish;
  end

  task automatic drive_item(logic func, logic [2:0] b, logic [31:0] now, logic pin,
                            logic [15:0] cnt);
    bpc_pkg::in_item_t it;
    int unsigned       gap;
    int unsigned       r;
    it.func = func;
    it.button = b;
    it.now = now;
    it.pin_level = pin;
    it.debounce_count = cnt;
    r = $urandom_range(0, 99);
    if (in_quiet || r < 55) gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_beat <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(logic [3:0] nb, logic [15:0] ld, logic [15:0] vld,
                               logic [15:0] db, logic [7:0] levels);
    hold_until_drained();
    write_reg(bpc_pkg::CFG_NUM_BUTTONS, 16'(nb));
    write_reg(bpc_pkg::CFG_LONG_DELAY, ld);
    write_reg(bpc_pkg::CFG_VERY_LONG_DELAY, vld);
    write_reg(bpc_pkg::CFG_DEFAULT_DEBOUNCE, db);
    write_reg(bpc_pkg::CFG_INITIAL_LEVELS, 16'(levels));
  endtask

  function automatic int unsigned hold_step();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 32'(tracker.very_long_delay) + 2);
    return $urandom_range(0, 32'(tracker.long_delay) / 3 + 2);
  endfunction

  function automatic logic [2:0] pick_button();
    if (tracker.num_buttons == 0 || $urandom_range(0, 9) == 0) return 3'($urandom);
    return 3'($urandom_range(0, 32'(tracker.num_buttons) - 1));
  endfunction

  // debounced press, a run of hold polls, then mostly a debounced release
  task automatic run_press(logic [2:0] b);
    logic [15:0] cnt;
    int unsigned settle;
    cnt = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 30));
    settle = (cnt == 0) ? 32'(tracker.default_debounce) : 32'(cnt);
    drive_item(bpc_pkg::FUNC_EDGE, b, tick_now, 1'($urandom), cnt);
    tick_now += settle + $urandom_range(0, 2);
    drive_item(bpc_pkg::FUNC_POLL, b, tick_now, 1'b1, 16'($urandom));
    repeat ($urandom_range(2, 10)) begin
      tick_now += hold_step();
      drive_item(bpc_pkg::FUNC_POLL, b, tick_now, 1'($urandom), 16'($urandom));
    end
    if ($urandom_range(0, 9) == 0) return;
    cnt = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 30));
    settle = (cnt == 0) ? 32'(tracker.default_debounce) : 32'(cnt);
    drive_item(bpc_pkg::FUNC_EDGE, b, tick_now, 1'($urandom), cnt);
    tick_now += settle + $urandom_range(0, 2);
    drive_item(bpc_pkg::FUNC_POLL, b, tick_now, 1'b0, 16'($urandom));
    repeat ($urandom_range(2, 3)) begin
      tick_now += $urandom_range(0, 3);
      drive_item(bpc_pkg::FUNC_POLL, b, tick_now, 1'($urandom), 16'($urandom));
    end
  endtask

  task automatic run_phase(int unsigned n_items);
    int unsigned stop_at;
    int unsigned r;
    logic [2:0]  b;
    bit          paused;
    stop_at = items_sent + n_items;
    paused = 1'b0;
    tick_now = $urandom;
    while (items_sent < stop_at) begin
      if (!paused && items_sent >= stop_at - n_items / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
      b = pick_button();
      r = $urandom_range(0, 9);
      if (r < 2) begin
        drive_item(1'($urandom), 3'($urandom), $urandom, 1'($urandom), 16'($urandom));
      end else if (r < 9) begin
        run_press(b);
        // quick second press, which may land inside the double-press window
        if ($urandom_range(0, 2) == 0) begin
          tick_now += $urandom_range(0, 32'(tracker.long_delay));
          run_press(b);
        end
      end else begin
        // bounce: poll soon after the edge, mostly before the debounce has run out
        drive_item(bpc_pkg::FUNC_EDGE, b, tick_now, 1'($urandom),
                   16'($urandom_range(0, 20)));
        drive_item(bpc_pkg::FUNC_POLL, b, tick_now + $urandom_range(0, 3), 1'($urandom),
                   16'($urandom));
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // no buttons registered yet
    drive_item(bpc_pkg::FUNC_EDGE, 3'd0, 32'd10, 1'b0, 16'd0);
    drive_item(bpc_pkg::FUNC_POLL, 3'd7, 32'd20, 1'b1, 16'd0);

    apply_setting(4'd8, 16'd100, 16'd300, 16'd50, 8'h00);
    // default debounce, boundary poll, then short, long, very long and release
    drive_item(bpc_pkg::FUNC_EDGE, 3'd0, 32'd1000, 1'b0, 16'd0);
    drive_item(bpc_pkg::FUNC_POLL, 3'd0, 32'd1050, 1'b1, 16'd0);
    drive_item(bpc_pkg::FUNC_POLL, 3'd0, 32'd1051, 1'b1, 16'd0);
    drive_item(bpc_pkg::FUNC_POLL, 3'd0, 32'd1060, 1'b1, 16'd0);
    drive_item(bpc_pkg::FUNC_POLL, 3'd0, 32'd1070, 1'b1, 16'd0);
    drive_item(bpc_pkg::FUNC_POLL, 3'd0, 32'd1080, 1'b1, 16'd0);
    drive_item(bpc_pkg::FUNC_POLL, 3'd0, 32'd1161, 1'b1, 16'd0);
    drive_item(bpc_pkg::FUNC_POLL, 3'd0, 32'd1170, 1'b1, 16'd0);
    drive_item(bpc_pkg::FUNC_POLL, 3'd0, 32'd1361, 1'b1, 16'd0);
    drive_item(bpc_pkg::FUNC_POLL, 3'd0, 32'd1370, 1'b1, 16'd0);
    drive_item(bpc_pkg::FUNC_EDGE, 3'd0, 32'd1400, 1'b1, 16'd5);
    drive_item(bpc_pkg::FUNC_POLL, 3'd0, 32'd1406, 1'b0, 16'd0);
    drive_item(bpc_pkg::FUNC_POLL, 3'd0, 32'd1407, 1'b0, 16'd0);
    drive_item(bpc_pkg::FUNC_POLL, 3'd0, 32'd1408, 1'b0, 16'd0);
    // re-press inside the window gives a double press
    drive_item(bpc_pkg::FUNC_EDGE, 3'd0, 32'd1410, 1'b0, 16'd2);
    drive_item(bpc_pkg::FUNC_POLL, 3'd0, 32'd1413, 1'b1, 16'd0);
    drive_item(bpc_pkg::FUNC_POLL, 3'd0, 32'd1414, 1'b1, 16'd0);
    drive_item(bpc_pkg::FUNC_POLL, 3'd0, 32'd1415, 1'b1, 16'd0);
    drive_item(bpc_pkg::FUNC_POLL, 3'd0, 32'd1416, 1'b1, 16'd0);
    drive_item(bpc_pkg::FUNC_POLL, 3'd0, 32'd1417, 1'b1, 16'd0);
    // deadline wrapping to zero reads as nothing pending; a wrapped nonzero deadline still expires
    drive_item(bpc_pkg::FUNC_EDGE, 3'd1, 32'hFFFF_FFF0, 1'b1, 16'd16);
    drive_item(bpc_pkg::FUNC_POLL, 3'd1, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    drive_item(bpc_pkg::FUNC_EDGE, 3'd7, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    drive_item(bpc_pkg::FUNC_POLL, 3'd7, 32'h0000_FFFF, 1'b1, 16'hFFFF);

    apply_setting(4'd8, 16'd100, 16'd300, 16'd20, 8'($urandom));
    run_phase(300);
    apply_setting(4'd5, 16'd0, 16'd0, 16'd0, 8'hFF);
    run_phase(250);
    apply_setting(4'd8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00);
    run_phase(250);
    apply_setting(4'($urandom_range(1, 4)), 16'($urandom_range(1, 200)),
                  16'($urandom_range(1, 600)), 16'($urandom_range(1, 40)), 8'($urandom));
    run_phase(250);
    apply_setting(4'd0, 16'd1000, 16'd2000, 16'd50, 8'h5A);
    run_phase(50);
    apply_setting(4'd8, 16'($urandom_range(10, 500)), 16'($urandom_range(10, 1500)),
                  16'($urandom_range(0, 60)), 8'($urandom));
    run_phase(300);

    hold_until_drained();
    repeat (10) @(posedge clk);
    if (tracker.awaited.size() != 0) begin
      tracker.errors++;
      $display("%0t: %0d results never arrived", $time, tracker.awaited.size());
    end
    $display("run: %0d items sent over seven register settings, %0d results checked, %0d rejected",
             items_sent, tracker.matched, tracker.rejected);
    $display("events: short %0d long %0d very long %0d double %0d release %0d",
             tracker.event_hits[bpc_pkg::EV_SHORT], tracker.event_hits[bpc_pkg::EV_LONG],
             tracker.event_hits[bpc_pkg::EV_VLONG], tracker.event_hits[bpc_pkg::EV_DOUBLE],
             tracker.event_hits[bpc_pkg::EV_RELEASE]);
    if (tracker.errors == 0) begin
      $display("PASS button_press_classifier_unit");
    end else begin
      $display("FAIL button_press_classifier_unit");
    end
    $finish;
  end

endmodule
